// File: hw/rtl/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// Nearest free slot allocator package
// Widths, payload structs, state encodings and the records passed between the
// request sequencer and the tree walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfsa_pkg;

	localparam int MAX_SLOTS  = 1024;
	localparam int SLOT_W     = 11;
	localparam int NODE_W     = $clog2(MAX_SLOTS) + 1;
	localparam int TREE_DEPTH = 2 ** NODE_W;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [NODE_W-1:0] node_t;

	localparam logic REQ_CLAIM   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_FULL     = 2'd1,
		ST_RELEASED = 2'd2,
		ST_BAD      = 2'd3
	} status_t;

	typedef struct packed {
		logic  req_type;
		slot_t position;
	} req_t;

	typedef struct packed {
		slot_t   granted_position;
		status_t status;
	} rsp_t;

	typedef enum logic [1:0] {
		WALK_COUNT,
		WALK_KTH,
		WALK_TAKE,
		WALK_FREE
	} walk_mode_t;

	typedef enum logic [1:0] {
		WK_IDLE,
		WK_READ,
		WK_EVAL
	} walk_state_t;

	typedef enum logic [3:0] {
		SQ_CLEAR,
		SQ_IDLE,
		SQ_CNT_GO,
		SQ_CNT_WAIT,
		SQ_DECIDE,
		SQ_ABV_GO,
		SQ_ABV_WAIT,
		SQ_BLW_GO,
		SQ_BLW_WAIT,
		SQ_PICK,
		SQ_UPD_GO,
		SQ_UPD_WAIT,
		SQ_FIN
	} seq_state_t;

	typedef struct packed {
		logic       start;
		walk_mode_t mode;
		slot_t      key;
	} walk_cmd_t;

	typedef struct packed {
		logic  done;
		slot_t lower_free;
		logic  leaf_taken;
		slot_t slot;
	} walk_rsp_t;

	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		slot_t wr_data;
	} mem_req_t;

endpackage

// File: hw/rtl/nfsa_tree_ram.sv
// ----------------------------------------------------------------------------
// Tree node RAM
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfsa_tree_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 11
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/nfsa_walker.sv
// ----------------------------------------------------------------------------
// Tree walker
// Descends the taken-count tree from the root, one level per read. It counts
// free slots left of a position, finds the k-th free slot, or adjusts the
// taken counts along the path to one slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfsa_walker (
	input  logic               clk,
	input  logic               arst_n,
	input  nfsa_pkg::walk_cmd_t cmd,
	input  nfsa_pkg::slot_t    slots,
	input  nfsa_pkg::slot_t    rd_data,
	output nfsa_pkg::mem_req_t mem,
	output nfsa_pkg::walk_rsp_t rsp
);

	import nfsa_pkg::*;

	walk_state_t state_q, state_d;
	walk_mode_t  mode_q;
	slot_t       key_q, lo_q, hi_q, mid_q, lsize_q, acc_q;
	node_t       node_q;
	logic        leaf_q, done_q;

	logic        at_leaf, is_update, go_left;
	node_t       left_node;
	slot_t       left_free;
	logic [SLOT_W:0] range_sum;

	// The tree holds taken counts; free counts come from the node's range size.
	assign at_leaf   = (lo_q == hi_q);
	assign is_update = (mode_q == WALK_TAKE) || (mode_q == WALK_FREE);
	assign left_node = {node_q[NODE_W-2:0], 1'b0};
	assign left_free = lsize_q - rd_data;
	assign range_sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		if (mode_q == WALK_KTH) begin
			go_left = (left_free >= key_q);
		end else begin
			go_left = (key_q <= mid_q);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			WK_IDLE: begin
				if (cmd.start) begin
					state_d = WK_READ;
				end
			end
			WK_READ: begin
				if (mode_q == WALK_KTH && at_leaf) begin
					state_d = WK_IDLE;
				end else begin
					state_d = WK_EVAL;
				end
			end
			WK_EVAL: begin
				if (mode_q != WALK_KTH && at_leaf) begin
					state_d = WK_IDLE;
				end else begin
					state_d = WK_READ;
				end
			end
			default: state_d = WK_IDLE;
		endcase
	end

	always_comb begin
		mem.rd_en   = (state_q == WK_READ) && !(mode_q == WALK_KTH && at_leaf);
		mem.rd_addr = (at_leaf || is_update) ? node_q : left_node;
		mem.wr_en   = (state_q == WK_EVAL) && is_update;
		mem.wr_addr = node_q;
		if (mode_q == WALK_TAKE) begin
			mem.wr_data = rd_data + slot_t'(1);
		end else begin
			mem.wr_data = rd_data - slot_t'(1);
		end
		rsp.done       = done_q;
		rsp.lower_free = acc_q;
		rsp.leaf_taken = leaf_q;
		rsp.slot       = lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q != WK_IDLE) && (state_d == WK_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == WK_IDLE && cmd.start) begin
			mode_q <= cmd.mode;
			key_q  <= cmd.key;
			node_q <= node_t'(1);
			lo_q   <= slot_t'(1);
			hi_q   <= slots;
			acc_q  <= '0;
		end
		if (state_q == WK_READ) begin
			mid_q   <= range_sum[SLOT_W:1];
			lsize_q <= ((hi_q - lo_q) >> 1) + slot_t'(1);
		end
		if (state_q == WK_EVAL) begin
			if (at_leaf) begin
				leaf_q <= (rd_data != '0);
			end else if (go_left) begin
				node_q <= left_node;
				hi_q   <= mid_q;
			end else begin
				node_q <= left_node | node_t'(1);
				lo_q   <= mid_q + slot_t'(1);
				if (mode_q == WALK_COUNT) begin
					acc_q <= acc_q + left_free;
				end
				if (mode_q == WALK_KTH) begin
					key_q <= key_q - left_free;
				end
			end
		end
	end

endmodule

// File: hw/rtl/nearest_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// Nearest free slot allocator
// A claim takes the free slot nearest the wanted position, the lower one on a
// tie; a release frees one slot. Slots 1 to slots_in_use are tracked in a
// segment tree of taken counts held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; each tree level is a read of the node
// from the tree RAM followed by an evaluation of it. A request naming a
// position out of range is answered without a walk of the tree. A response
// is offered once the output register is free, and the sequencer is ready for
// the next request in the same cycle as the response is offered. A finished
// response waits in an output register, so the next request is taken while
// it is pending. After reset and after every write of the size register the
// block clears the tree RAM, during which no request is taken; all slots are
// then free.
`timescale 1ns / 1ps

module nearest_free_slot_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  nfsa_pkg::slot_t cfg_data,
	input  logic            req_valid,
	output logic            req_ready,
	input  nfsa_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output nfsa_pkg::rsp_t  rsp_data
);

	import nfsa_pkg::*;

	seq_state_t state_q, state_d;
	slot_t      slots_q, free_q;
	node_t      clr_q;
	logic       req_type_q, leaf_taken_q, has_above_q, has_below_q;
	slot_t      pos_q, before_q, above_q, below_q, pick_q;
	status_t    status_q;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	walk_cmd_t  wcmd;
	walk_rsp_t  wrsp;
	mem_req_t   wmem;
	slot_t      rd_data;
	logic       ram_wr_en;
	node_t      ram_wr_addr;
	slot_t      ram_wr_data;

	slot_t      cfg_slots, upto;
	logic       range_bad, has_above_c, has_below_c, rsp_load;

	always_comb begin
		if (cfg_data == '0) begin
			cfg_slots = slot_t'(1);
		end else if (cfg_data > slot_t'(MAX_SLOTS)) begin
			cfg_slots = slot_t'(MAX_SLOTS);
		end else begin
			cfg_slots = cfg_data;
		end
	end

	assign range_bad   = (req_data.position == '0) || (req_data.position > slots_q);
	assign upto        = before_q + slot_t'(!leaf_taken_q);
	assign has_above_c = (before_q < free_q);
	assign has_below_c = (upto != '0);
	assign rsp_load    = (state_q == SQ_FIN) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		state_d = state_q;
		if (cfg_valid) begin
			state_d = SQ_CLEAR;
		end else begin
			unique case (state_q)
				SQ_CLEAR: begin
					if (clr_q == node_t'(TREE_DEPTH - 1)) begin
						state_d = SQ_IDLE;
					end
				end
				SQ_IDLE: begin
					if (req_valid) begin
						state_d = range_bad ? SQ_FIN : SQ_CNT_GO;
					end
				end
				SQ_CNT_GO: state_d = SQ_CNT_WAIT;
				SQ_CNT_WAIT: begin
					if (wrsp.done) begin
						state_d = SQ_DECIDE;
					end
				end
				SQ_DECIDE: begin
					if (req_type_q == REQ_RELEASE) begin
						state_d = leaf_taken_q ? SQ_UPD_GO : SQ_FIN;
					end else if (!leaf_taken_q) begin
						state_d = SQ_UPD_GO;
					end else if (has_above_c) begin
						state_d = SQ_ABV_GO;
					end else if (has_below_c) begin
						state_d = SQ_BLW_GO;
					end else begin
						state_d = SQ_FIN;
					end
				end
				SQ_ABV_GO: state_d = SQ_ABV_WAIT;
				SQ_ABV_WAIT: begin
					if (wrsp.done) begin
						state_d = has_below_q ? SQ_BLW_GO : SQ_PICK;
					end
				end
				SQ_BLW_GO: state_d = SQ_BLW_WAIT;
				SQ_BLW_WAIT: begin
					if (wrsp.done) begin
						state_d = SQ_PICK;
					end
				end
				SQ_PICK: state_d = SQ_UPD_GO;
				SQ_UPD_GO: state_d = SQ_UPD_WAIT;
				SQ_UPD_WAIT: begin
					if (wrsp.done) begin
						state_d = SQ_FIN;
					end
				end
				SQ_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_d = SQ_IDLE;
					end
				end
				default: state_d = SQ_CLEAR;
			endcase
		end
	end

	always_comb begin
		cfg_ready = 1'b1;
		// A size write wins over a request offered in the same cycle.
		req_ready = (state_q == SQ_IDLE) && !cfg_valid;
		rsp_valid = rsp_valid_q;
		rsp_data  = rsp_q;

		wcmd.start = 1'b0;
		wcmd.mode  = WALK_COUNT;
		wcmd.key   = pos_q;
		unique case (state_q)
			SQ_CNT_GO: begin
				wcmd.start = 1'b1;
			end
			SQ_ABV_GO: begin
				wcmd.start = 1'b1;
				wcmd.mode  = WALK_KTH;
				wcmd.key   = before_q + slot_t'(1);
			end
			SQ_BLW_GO: begin
				wcmd.start = 1'b1;
				wcmd.mode  = WALK_KTH;
				wcmd.key   = upto;
			end
			SQ_UPD_GO: begin
				wcmd.start = 1'b1;
				wcmd.mode  = (req_type_q == REQ_RELEASE) ? WALK_FREE : WALK_TAKE;
				wcmd.key   = pick_q;
			end
			default: begin
			end
		endcase

		// The clearing pass owns the write port; any walker write is then dropped.
		if (state_q == SQ_CLEAR) begin
			ram_wr_en   = 1'b1;
			ram_wr_addr = clr_q;
			ram_wr_data = '0;
		end else begin
			ram_wr_en   = wmem.wr_en;
			ram_wr_addr = wmem.wr_addr;
			ram_wr_data = wmem.wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_CLEAR;
			slots_q     <= slot_t'(MAX_SLOTS);
			free_q      <= slot_t'(MAX_SLOTS);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				slots_q <= cfg_slots;
				free_q  <= cfg_slots;
				clr_q   <= '0;
			end else begin
				if (state_q == SQ_CLEAR) begin
					clr_q <= clr_q + node_t'(1);
				end
				if (state_q == SQ_UPD_WAIT && wrsp.done) begin
					if (req_type_q == REQ_RELEASE) begin
						free_q <= free_q + slot_t'(1);
					end else begin
						free_q <= free_q - slot_t'(1);
					end
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_IDLE && req_valid) begin
			req_type_q <= req_data.req_type;
			pos_q      <= req_data.position;
			status_q   <= ST_BAD;
		end
		if (state_q == SQ_CNT_WAIT && wrsp.done) begin
			before_q     <= wrsp.lower_free;
			leaf_taken_q <= wrsp.leaf_taken;
		end
		if (state_q == SQ_DECIDE) begin
			has_above_q <= has_above_c;
			has_below_q <= has_below_c;
			pick_q      <= pos_q;
			if (req_type_q == REQ_RELEASE) begin
				status_q <= leaf_taken_q ? ST_RELEASED : ST_BAD;
			end else if (!leaf_taken_q) begin
				status_q <= ST_GRANTED;
			end else if (!has_above_c && !has_below_c) begin
				status_q <= ST_FULL;
			end
		end
		if (state_q == SQ_ABV_WAIT && wrsp.done) begin
			above_q <= wrsp.slot;
		end
		if (state_q == SQ_BLW_WAIT && wrsp.done) begin
			below_q <= wrsp.slot;
		end
		if (state_q == SQ_PICK) begin
			status_q <= ST_GRANTED;
			// Equal distance goes to the lower slot.
			if (!has_above_q) begin
				pick_q <= below_q;
			end else if (!has_below_q) begin
				pick_q <= above_q;
			end else if ((pos_q - below_q) <= (above_q - pos_q)) begin
				pick_q <= below_q;
			end else begin
				pick_q <= above_q;
			end
		end
		if (rsp_load) begin
			rsp_q.status           <= status_q;
			rsp_q.granted_position <= (status_q == ST_GRANTED) ? pick_q : '0;
		end
	end

	nfsa_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (wcmd),
		.slots   (slots_q),
		.rd_data (rd_data),
		.mem     (wmem),
		.rsp     (wrsp)
	);

	nfsa_tree_ram #(
		.ADDR_W (NODE_W),
		.DATA_W (SLOT_W)
	) u_tree_ram (
		.clk     (clk),
		.rd_en   (wmem.rd_en),
		.rd_addr (wmem.rd_addr),
		.rd_data (rd_data),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data)
	);

endmodule
